>>> rtl/core/ptint_pkg.sv
// shared constants, codes and controller/datapath interface types
package ptint_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_COMPONENTS_DEF = 4;

  localparam int DVD_W = 49;
  localparam int DIVISOR_W = 32;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MOD_STEPS = 6'd33;
  localparam logic [CNT_W-1:0] ALPHA_STEPS = 6'd49;

  localparam logic [1:0] CMD_WR_TIME = 2'd0;
  localparam logic [1:0] CMD_WR_VALUE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_COMPONENT_COUNT = 2'd1;
  localparam logic [1:0] CFG_WRAP_MODE = 2'd2;

  typedef enum logic [2:0] {
    TS_FIRST,
    TS_LAST,
    TS_MID,
    TS_A,
    TS_B
  } tsel_t;

  typedef struct packed {
    logic  take;
    tsel_t tsel;
    logic  vsel_b;
    logic  cap_t0;
    logic  cap_t1;
    logic  pin_first;
    logic  mod_load;
    logic  mod_fix;
    logic  clamp;
    logic  srch_mid;
    logic  srch_cmp;
    logic  srch_end;
    logic  cap_ta;
    logic  cap_tb;
    logic  alpha_load;
    logic  alpha_zero;
    logic  div_step;
    logic  alpha_set;
    logic  cap_va;
    logic  cap_dv;
    logic  mul;
    logic  load_out;
  } ctrl_t;

  typedef struct packed {
    logic is_query;
    logic q_short;
    logic single;
    logic wrap_go;
    logic tt_end;
    logic srch_open;
    logic dt_pos;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/ptint_div.sv
// bit-serial restoring divider, one quotient bit a cycle while step is held
module ptint_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic                               step,
  input  logic [ptint_pkg::CNT_W-1:0]        steps,
  input  logic [ptint_pkg::DVD_W-1:0]        dividend,
  input  logic [ptint_pkg::DIVISOR_W-1:0]    divisor,
  output logic [ptint_pkg::DIVISOR_W-1:0]    remainder,
  output logic [ptint_pkg::DVD_W-1:0]        quotient,
  output logic                               last
);

  logic [ptint_pkg::DIVISOR_W-1:0] dsr;
  logic [ptint_pkg::CNT_W-1:0]     cnt;
  logic [ptint_pkg::DIVISOR_W:0]   trial;
  logic                            ge;

  assign trial = {remainder, quotient[ptint_pkg::DVD_W-1]};
  assign ge = trial >= {1'b0, dsr};
  assign last = cnt == ptint_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= steps;
    end else if (step && cnt != '0) begin
      cnt <= cnt - ptint_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      remainder <= '0;
      quotient <= dividend;
      dsr <= divisor;
    end else if (step) begin
      remainder <= ge ? ptint_pkg::DIVISOR_W'(trial - {1'b0, dsr})
                      : ptint_pkg::DIVISOR_W'(trial);
      quotient <= {quotient[ptint_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/ptint_ctrl.sv
// query sequencer state machine
module ptint_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ptint_pkg::stat_t st,
  output ptint_pkg::ctrl_t ctl
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'b00000000000000000001,
    S_RD0   = 20'b00000000000000000010,
    S_RD1   = 20'b00000000000000000100,
    S_RDE   = 20'b00000000000000001000,
    S_MOD   = 20'b00000000000000010000,
    S_WFIX  = 20'b00000000000000100000,
    S_CLAMP = 20'b00000000000001000000,
    S_SA    = 20'b00000000000010000000,
    S_SC    = 20'b00000000000100000000,
    S_TA    = 20'b00000000001000000000,
    S_TB    = 20'b00000000010000000000,
    S_TD    = 20'b00000000100000000000,
    S_DT    = 20'b00000001000000000000,
    S_DIV   = 20'b00000010000000000000,
    S_AL    = 20'b00000100000000000000,
    S_VA    = 20'b00001000000000000000,
    S_VB    = 20'b00010000000000000000,
    S_VC    = 20'b00100000000000000000,
    S_MUL   = 20'b01000000000000000000,
    S_DONE  = 20'b10000000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.tsel = ptint_pkg::TS_FIRST;
    unique case (state)
      S_IDLE: begin
        ctl.take = 1'b1;
        if (in_valid && st.is_query) begin
          state_next = st.q_short ? S_DONE : S_RD0;
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: begin
        ctl.tsel = ptint_pkg::TS_LAST;
        ctl.cap_t0 = 1'b1;
        state_next = S_RDE;
      end
      S_RDE: begin
        ctl.cap_t1 = 1'b1;
        if (st.single) begin
          ctl.pin_first = 1'b1;
          state_next = S_VA;
        end else if (st.wrap_go) begin
          ctl.mod_load = 1'b1;
          state_next = S_MOD;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_MOD: begin
        ctl.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_WFIX;
        end
      end
      S_WFIX: begin
        ctl.mod_fix = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        ctl.clamp = 1'b1;
        state_next = st.tt_end ? S_VA : S_SA;
      end
      S_SA: begin
        ctl.tsel = ptint_pkg::TS_MID;
        if (st.srch_open) begin
          ctl.srch_mid = 1'b1;
          state_next = S_SC;
        end else begin
          ctl.srch_end = 1'b1;
          state_next = S_TA;
        end
      end
      S_SC: begin
        ctl.srch_cmp = 1'b1;
        state_next = S_SA;
      end
      S_TA: begin
        ctl.tsel = ptint_pkg::TS_A;
        state_next = S_TB;
      end
      S_TB: begin
        ctl.tsel = ptint_pkg::TS_B;
        ctl.cap_ta = 1'b1;
        state_next = S_TD;
      end
      S_TD: begin
        ctl.cap_tb = 1'b1;
        state_next = S_DT;
      end
      S_DT: begin
        if (st.dt_pos) begin
          ctl.alpha_load = 1'b1;
          state_next = S_DIV;
        end else begin
          ctl.alpha_zero = 1'b1;
          state_next = S_VA;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_AL;
        end
      end
      S_AL: begin
        ctl.alpha_set = 1'b1;
        state_next = S_VA;
      end
      S_VA: state_next = S_VB;
      S_VB: begin
        ctl.vsel_b = 1'b1;
        ctl.cap_va = 1'b1;
        state_next = S_VC;
      end
      S_VC: begin
        ctl.cap_dv = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/ptint_dp.sv
// datapath: tables, config registers, search, divider, interpolation, output word
module ptint_dp #(
  parameter int MAX_POINTS = ptint_pkg::MAX_POINTS_DEF,
  parameter int MAX_COMPONENTS = ptint_pkg::MAX_COMPONENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic [1:0]         cmd,
  input  logic [5:0]         point_index,
  input  logic [1:0]         component_sel,
  input  logic signed [31:0] time_word,
  input  logic signed [31:0] sample_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] interp_value,
  output logic               status,
  input  ptint_pkg::ctrl_t   ctl,
  output ptint_pkg::stat_t   st
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int VD = MAX_POINTS * MAX_COMPONENTS;
  localparam int VAW = (VD > 1) ? $clog2(VD) : 1;

  logic [6:0] point_count;
  logic [2:0] component_count;
  logic       wrap_mode;

  logic [31:0] time_mem [MAX_POINTS];
  logic [31:0] value_mem [VD];
  logic [AW-1:0]  tm_addr;
  logic [VAW-1:0] vm_addr, vm_waddr;
  logic [31:0] tm_rdata, vm_rdata;

  logic accept, wr_time, wr_value;
  logic [NW-1:0] n, n_m1, lo, hi;
  logic [NW:0]   sum;
  logic [AW-1:0] mid_c, mid, ia, ib;
  logic [NW-1:0] i1;

  logic signed [31:0] qtime, t0, t1, tt, ta, tb, va;
  logic [1:0]         qcomp;
  logic               res_err, res_zero, dneg;
  logic [31:0]        span;
  logic signed [32:0] span_c, d_c, nm_c, dt_c, dv;
  logic [32:0]        absd, numc;
  logic [31:0]        rr;
  logic [16:0]        alpha;
  logic signed [50:0] prod;

  logic                            div_load;
  logic [ptint_pkg::CNT_W-1:0]     div_steps;
  logic [ptint_pkg::DVD_W-1:0]     div_dvd, div_quo;
  logic [ptint_pkg::DIVISOR_W-1:0] div_dsr, div_rem;
  logic                            div_last;

  function automatic logic res_err_c();
    res_err_c = 32'(component_sel) >= 32'(component_count)
                || 32'(component_sel) >= MAX_COMPONENTS;
  endfunction

  assign accept = in_valid && ctl.take;
  assign wr_time = accept && cmd == ptint_pkg::CMD_WR_TIME
                   && 32'(point_index) < MAX_POINTS;
  assign wr_value = accept && cmd == ptint_pkg::CMD_WR_VALUE
                    && 32'(point_index) < MAX_POINTS
                    && 32'(component_sel) < MAX_COMPONENTS;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 7'd0;
      component_count <= 3'd1;
      wrap_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptint_pkg::CFG_POINT_COUNT:     point_count <= cfg_wdata;
        ptint_pkg::CFG_COMPONENT_COUNT: component_count <= cfg_wdata[2:0];
        ptint_pkg::CFG_WRAP_MODE:       wrap_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign n = (32'(point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count);
  assign n_m1 = n - NW'(1);
  assign sum = {1'b0, lo} + {1'b0, hi};
  assign mid_c = AW'(sum >> 1);

  always_comb begin
    unique case (ctl.tsel)
      ptint_pkg::TS_FIRST: tm_addr = '0;
      ptint_pkg::TS_LAST:  tm_addr = AW'(n_m1);
      ptint_pkg::TS_MID:   tm_addr = mid_c;
      ptint_pkg::TS_A:     tm_addr = ia;
      ptint_pkg::TS_B:     tm_addr = ib;
      default:             tm_addr = '0;
    endcase
  end

  assign vm_addr = VAW'(32'(ctl.vsel_b ? ib : ia) * MAX_COMPONENTS + 32'(qcomp));
  assign vm_waddr = VAW'(32'(point_index) * MAX_COMPONENTS + 32'(component_sel));

  always_ff @(posedge clk) begin
    if (wr_time) begin
      time_mem[AW'(point_index)] <= time_word;
    end
    tm_rdata <= time_mem[tm_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_value) begin
      value_mem[vm_waddr] <= sample_word;
    end
    vm_rdata <= value_mem[vm_addr];
  end

  assign span_c = $signed({tm_rdata[31], tm_rdata}) - $signed({t0[31], t0});
  assign d_c = $signed({qtime[31], qtime}) - $signed({t0[31], t0});
  assign absd = d_c[32] ? 33'(-d_c) : 33'(d_c);
  assign rr = (dneg && div_rem != '0) ? span - div_rem : div_rem;
  assign nm_c = $signed({tt[31], tt}) - $signed({ta[31], ta});
  assign dt_c = $signed({tb[31], tb}) - $signed({ta[31], ta});

  always_comb begin
    if (nm_c < 0) begin
      numc = '0;
    end else if (nm_c > dt_c) begin
      numc = 33'(dt_c);
    end else begin
      numc = 33'(nm_c);
    end
  end

  always_comb begin
    if (lo == '0) begin
      i1 = NW'(1);
    end else if (lo > n_m1) begin
      i1 = n_m1;
    end else begin
      i1 = lo;
    end
  end

  assign div_load = ctl.mod_load || ctl.alpha_load;
  assign div_steps = ctl.mod_load ? ptint_pkg::MOD_STEPS : ptint_pkg::ALPHA_STEPS;
  assign div_dvd = ctl.mod_load ? {absd, 16'd0} : {1'b0, numc[31:0], 16'd0};
  assign div_dsr = ctl.mod_load ? span_c[31:0] : dt_c[31:0];

  ptint_div u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .step      (ctl.div_step),
    .steps     (div_steps),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .remainder (div_rem),
    .quotient  (div_quo),
    .last      (div_last)
  );

  always_ff @(posedge clk) begin
    if (accept && cmd == ptint_pkg::CMD_QUERY) begin
      qtime <= time_word;
      qcomp <= component_sel;
      res_err <= st.q_short && !(point_count == 7'd0 && !res_err_c());
      res_zero <= st.q_short;
    end
    if (ctl.cap_t0) begin
      t0 <= tm_rdata;
    end
    if (ctl.cap_t1) begin
      t1 <= tm_rdata;
      tt <= qtime;
      span <= span_c[31:0];
      dneg <= d_c[32];
    end
    if (ctl.pin_first) begin
      ia <= '0;
      ib <= '0;
      alpha <= '0;
    end
    if (ctl.mod_fix) begin
      tt <= t0 + $signed(rr);
    end
    if (ctl.clamp) begin
      lo <= '0;
      hi <= n;
      alpha <= '0;
      if (tt <= t0) begin
        ia <= '0;
        ib <= '0;
      end else begin
        ia <= AW'(n_m1);
        ib <= AW'(n_m1);
      end
    end
    if (ctl.srch_mid) begin
      mid <= mid_c;
    end
    if (ctl.srch_cmp) begin
      if ($signed(tm_rdata) <= tt) begin
        lo <= NW'(mid) + NW'(1);
      end else begin
        hi <= NW'(mid);
      end
    end
    if (ctl.srch_end) begin
      ib <= AW'(i1);
      ia <= AW'(i1 - NW'(1));
    end
    if (ctl.cap_ta) begin
      ta <= tm_rdata;
    end
    if (ctl.cap_tb) begin
      tb <= tm_rdata;
    end
    if (ctl.alpha_zero) begin
      alpha <= '0;
    end
    if (ctl.alpha_set) begin
      alpha <= div_quo[16:0];
    end
    if (ctl.cap_va) begin
      va <= vm_rdata;
    end
    if (ctl.cap_dv) begin
      dv <= $signed({vm_rdata[31], vm_rdata}) - $signed({va[31], va});
    end
    if (ctl.mul) begin
      prod <= dv * $signed({1'b0, alpha});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status <= res_err;
      interp_value <= res_zero ? 32'sd0 : va + prod[47:16];
    end
  end

  assign st.is_query = cmd == ptint_pkg::CMD_QUERY;
  assign st.q_short = res_err_c() || point_count == 7'd0;
  assign st.single = n == NW'(1);
  assign st.wrap_go = wrap_mode && !span_c[32] && span_c != '0;
  assign st.tt_end = tt <= t0 || tt >= t1;
  assign st.srch_open = lo < hi;
  assign st.dt_pos = !dt_c[32] && dt_c != '0;
  assign st.div_last = div_last;
  assign st.out_free = !out_valid || out_ready;

endmodule

>>> rtl/core/periodic_table_interpolator_core.sv
// piecewise linear table interpolator, top level
// A query on an out-of-range component or an empty table goes straight to the
// result word; a single point and a query that lands on an end of the table
// skip the search and the division. A query strictly inside the table runs a
// binary search (at most 7 steps for 64 points) and then the serial alpha
// division; periodic mode first runs the serial modulo. One bit-serial divider
// and one registered read of each table serve these steps, and a stalled
// output holds the sequencer until the previous word is taken. Table writes
// give no word. The block accepts a new word whenever its sequencer is idle,
// even while the last result word still waits on the output.
module periodic_table_interpolator_core #(
  parameter int MAX_POINTS = ptint_pkg::MAX_POINTS_DEF,
  parameter int MAX_COMPONENTS = ptint_pkg::MAX_COMPONENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [5:0]         point_index,
  input  logic [1:0]         component_sel,
  input  logic signed [31:0] time_word,
  input  logic signed [31:0] sample_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] interp_value,
  output logic               status
);

  ptint_pkg::ctrl_t ctl;
  ptint_pkg::stat_t st;

  assign in_ready = ctl.take;

  ptint_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .ctl      (ctl)
  );

  ptint_dp #(
    .MAX_POINTS     (MAX_POINTS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .cmd           (cmd),
    .point_index   (point_index),
    .component_sel (component_sel),
    .time_word     (time_word),
    .sample_word   (sample_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .interp_value  (interp_value),
    .status        (status),
    .ctl           (ctl),
    .st            (st)
  );

  a_write_no_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd != ptint_pkg::CMD_QUERY && !out_valid |=> !out_valid)
    else $error("table write produced a result word");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == ptint_pkg::CMD_QUERY |=> !in_ready)
    else $error("sequencer idle right after a query");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> interp_value == 32'sd0)
    else $error("error word with nonzero value");

endmodule
